// ----- rtl/core/motor_speed_pid_controller_defines.svh -----
// Assertion macros shared by the checker of the motor speed regulator.
`ifndef MOTOR_SPEED_PID_CONTROLLER_DEFINES_SVH
`define MOTOR_SPEED_PID_CONTROLLER_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define MSPC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the condition holds, the property must hold at the next edge.
`define MSPC_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- rtl/core/mspc_pkg.sv -----
// Package of the motor speed regulator: widths, codes, states and interface structs.
package mspc_pkg;

	localparam int DUTY_MAX   = 999;
	localparam int DUTY_W     = 10;
	localparam int SPEED_W    = 24;
	localparam int TARGET_W   = 8;
	localparam int ERR_W      = 26;
	localparam int ERR_MAG_W  = 24;
	localparam int DIF_MAG_W  = 25;
	localparam int GAIN_W     = 24;
	localparam int RATE_W     = 16;
	localparam int SCALE_W    = 32;
	localparam int INT_W      = 48;
	localparam int DRV_W      = 26;
	localparam int TERM_W     = 56;
	localparam int PART_W     = 54;
	localparam int DMAG_W     = 41;
	localparam int MUL_A_W    = 25;
	localparam int MUL_B_W    = 24;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 2;
	localparam int OUT_USED_W = DUTY_W + 1 + SPEED_W;
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [DUTY_W-1:0] DUTY_LIM  = DUTY_W'(DUTY_MAX);
	localparam logic [DRV_W-1:0]  DRIVE_TOP = DRV_W'(DUTY_MAX * 65536);
	localparam logic [INT_W-1:0]  INT_MAX   = {1'b0, {(INT_W-1){1'b1}}};
	localparam logic [INT_W-1:0]  INT_MIN   = {1'b1, {(INT_W-1){1'b0}}};

	localparam logic [GAIN_W-1:0]  KP_RESET    = 24'd209715;
	localparam logic [GAIN_W-1:0]  KI_RESET    = 24'd5243;
	localparam logic [GAIN_W-1:0]  KD_RESET    = 24'd0;
	localparam logic [GAIN_W-1:0]  PERIOD_RESET = 24'd16777;
	localparam logic [RATE_W-1:0]  RATE_RESET  = 16'd1000;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd4106952;

	typedef enum logic [IN_USER_W-1:0] {
		ACT_SETPOINT = 2'd0,
		ACT_MEASURE  = 2'd1,
		ACT_TICK     = 2'd2,
		ACT_NOP      = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KP     = 3'd0,
		CFG_KI     = 3'd1,
		CFG_KD     = 3'd2,
		CFG_PERIOD = 3'd3,
		CFG_RATE   = 3'd4,
		CFG_SCALE  = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_ERR,
		ST_M1,
		ST_INT,
		ST_IMAG,
		ST_P,
		ST_IL,
		ST_IH,
		ST_IA,
		ST_DH,
		ST_DA,
		ST_ACC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [SCALE_W-1:0]   dividend;
		logic [IN_DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [SCALE_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ----- rtl/core/motor_speed_pid_controller.sv -----
// Top level of the motor speed regulator: sequencer, shared multiplier and loop state.
//
// Items arrive on the s_ stream: s_tuser holds the action (setpoint, period
// measurement, control tick) and s_tdata the operand. Every accepted item
// yields exactly one result transfer on the m_ stream, carrying the held duty,
// the running flag and the measured speed after the item has been applied.
// Gains, sample period, sample rate and speed scale are written through the
// cfg_ port; the user must write them only while the block is idle, which the
// block itself does not enforce. They take effect on the next item.
//
// One item is worked on at a time and s_tready is low from acceptance until
// the result has been loaded into the output register. A control tick takes
// eleven steps through the single 25 by 24 bit multiplier and one adder, and
// a period measurement the 32 steps of the bit-serial divider. The output
// register parts the two sides: a stalled receiver holds the result steady
// and the block still accepts and works on the next item, which then waits
// in its final step until the output register is free.
// Reset restores the default configuration, clears all loop state and the
// duty value, and leaves the block idle with no result pending.
module motor_speed_pid_controller import mspc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // operand_value
	input  logic [IN_USER_W-1:0]  s_tuser,   // action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // duty, running, speed_rpm, zero padding
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [GAIN_W-1:0]  kp_q, ki_q, kd_q, period_q;
	logic [RATE_W-1:0]  rate_q;
	logic [SCALE_W-1:0] scale_q;

	action_t              action_q;
	logic [IN_DATA_W-1:0] operand_q;

	logic [TARGET_W-1:0] target_q;
	logic [SPEED_W-1:0]  meas_q;
	logic [ERR_W-1:0]    prev_err_q;
	logic [INT_W-1:0]    integ_q;
	logic [DRV_W-1:0]    drive_q;
	logic [DUTY_W-1:0]   duty_q;
	logic                enabled_q;

	logic                 err_neg_q, dif_neg_q, int_neg_q;
	logic [ERR_MAG_W-1:0] err_mag_q;
	logic [DIF_MAG_W-1:0] dif_mag_q;
	logic [INT_W-1:0]     int_mag_q;
	logic [DMAG_W-1:0]    dmag_q;
	logic [PROD_W-1:0]    prod_q;
	logic [PART_W-1:0]    part_q;
	logic [TERM_W-1:0]    term_q;

	logic [OUT_DATA_W-1:0] out_q;
	logic                  m_tvalid_q;
	logic                  out_free;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod_c;

	logic [ERR_W-1:0]   err_c;
	logic [ERR_W:0]     dif_c;
	logic [INT_W:0]     int_sum_c;
	logic [PART_W-1:0]  add_mag_c;
	logic               add_neg_c;
	logic [TERM_W-1:0]  term_c;
	logic [TERM_W:0]    acc_sum_c;
	logic [DRV_W-1:0]   drive_c;

	div_req_t div_req;
	div_rsp_t div_rsp;

	mspc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign div_req.start    = (state_q == ST_EXEC) && (action_q == ACT_MEASURE) &&
	                          (operand_q != '0);
	assign div_req.dividend = scale_q;
	assign div_req.divisor  = operand_q;

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (action_q)
					ACT_MEASURE: state_d = (operand_q != '0) ? ST_DIV : ST_DONE;
					ACT_TICK:    state_d = enabled_q ? ST_ERR : ST_DONE;
					default:     state_d = ST_DONE;
				endcase
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_ERR:  state_d = ST_M1;
			ST_M1:   state_d = ST_INT;
			ST_INT:  state_d = ST_IMAG;
			ST_IMAG: state_d = ST_P;
			ST_P:    state_d = ST_IL;
			ST_IL:   state_d = ST_IH;
			ST_IH:   state_d = ST_IA;
			ST_IA:   state_d = ST_DH;
			ST_DH:   state_d = ST_DA;
			ST_DA:   state_d = ST_ACC;
			ST_ACC:  state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_M1: begin
				mul_a = {1'b0, err_mag_q};
				mul_b = period_q;
			end
			ST_INT: begin
				mul_a = dif_mag_q;
				mul_b = {{(MUL_B_W-RATE_W){1'b0}}, rate_q};
			end
			ST_IMAG: begin
				mul_a = {1'b0, err_mag_q};
				mul_b = kp_q;
			end
			ST_P: begin
				mul_a = {1'b0, int_mag_q[23:0]};
				mul_b = ki_q;
			end
			ST_IL: begin
				mul_a = {1'b0, int_mag_q[47:24]};
				mul_b = ki_q;
			end
			ST_IH: begin
				mul_a = {1'b0, dmag_q[23:0]};
				mul_b = kd_q;
			end
			ST_IA: begin
				mul_a = {{(MUL_A_W-(DMAG_W-24)){1'b0}}, dmag_q[DMAG_W-1:24]};
				mul_b = kd_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_c = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

	assign err_c = {{(ERR_W-TARGET_W-8){1'b0}}, target_q, 8'd0} -
	               {{(ERR_W-SPEED_W){1'b0}}, meas_q};
	assign dif_c = {err_c[ERR_W-1], err_c} - {prev_err_q[ERR_W-1], prev_err_q};

	assign int_sum_c = err_neg_q ?
		{integ_q[INT_W-1], integ_q} - {9'd0, prod_q[47:8]} :
		{integ_q[INT_W-1], integ_q} + {9'd0, prod_q[47:8]};

	always_comb begin
		add_mag_c = '0;
		add_neg_c = 1'b0;
		case (state_q)
			ST_P: begin
				add_mag_c = {{(PART_W-(PROD_W-12)){1'b0}}, prod_q[PROD_W-1:12]};
				add_neg_c = err_neg_q;
			end
			ST_IA: begin
				add_mag_c = {4'd0, part_q[PART_W-1:4]};
				add_neg_c = int_neg_q;
			end
			ST_DA: begin
				add_mag_c = part_q;
				add_neg_c = dif_neg_q;
			end
			default: begin
				add_mag_c = '0;
				add_neg_c = 1'b0;
			end
		endcase
	end

	assign term_c = add_neg_c ? term_q - {2'd0, add_mag_c} : term_q + {2'd0, add_mag_c};

	assign acc_sum_c = {{(TERM_W+1-DRV_W){1'b0}}, drive_q} + {term_q[TERM_W-1], term_q};

	always_comb begin
		if (acc_sum_c[TERM_W]) begin
			drive_c = '0;
		end else if (acc_sum_c[TERM_W-1:0] > {{(TERM_W-DRV_W){1'b0}}, DRIVE_TOP}) begin
			drive_c = DRIVE_TOP;
		end else begin
			drive_c = acc_sum_c[DRV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= KP_RESET;
			ki_q     <= KI_RESET;
			kd_q     <= KD_RESET;
			period_q <= PERIOD_RESET;
			rate_q   <= RATE_RESET;
			scale_q  <= SCALE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_KP:     kp_q     <= cfg_data[GAIN_W-1:0];
				CFG_KI:     ki_q     <= cfg_data[GAIN_W-1:0];
				CFG_KD:     kd_q     <= cfg_data[GAIN_W-1:0];
				CFG_PERIOD: period_q <= cfg_data[GAIN_W-1:0];
				CFG_RATE:   rate_q   <= cfg_data[RATE_W-1:0];
				CFG_SCALE:  scale_q  <= cfg_data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= '0;
			meas_q     <= '0;
			prev_err_q <= '0;
			integ_q    <= '0;
			drive_q    <= '0;
			duty_q     <= '0;
			enabled_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_EXEC: begin
					if (action_q == ACT_SETPOINT) begin
						target_q <= operand_q[TARGET_W-1:0];
						if (operand_q[TARGET_W-1:0] != '0) begin
							enabled_q <= 1'b1;
						end else begin
							enabled_q  <= 1'b0;
							prev_err_q <= '0;
							integ_q    <= '0;
							drive_q    <= '0;
							meas_q     <= '0;
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						meas_q <= (div_rsp.quotient[SCALE_W-1:SPEED_W] != '0) ?
						          {SPEED_W{1'b1}} : div_rsp.quotient[SPEED_W-1:0];
					end
				end
				ST_ERR: begin
					prev_err_q <= err_c;
				end
				ST_INT: begin
					if (int_sum_c[INT_W] != int_sum_c[INT_W-1]) begin
						integ_q <= int_sum_c[INT_W] ? INT_MIN : INT_MAX;
					end else begin
						integ_q <= int_sum_c[INT_W-1:0];
					end
				end
				ST_ACC: begin
					drive_q <= drive_c;
					duty_q  <= drive_c[DRV_W-1:16];
				end
				default: begin
				end
			endcase
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		if (s_tvalid && s_tready) begin
			action_q  <= action_t'(s_tuser);
			operand_q <= s_tdata;
		end
		case (state_q)
			ST_ERR: begin
				err_neg_q <= err_c[ERR_W-1];
				err_mag_q <= err_c[ERR_W-1] ? ERR_MAG_W'(-err_c) : err_c[ERR_MAG_W-1:0];
				dif_neg_q <= dif_c[ERR_W];
				dif_mag_q <= dif_c[ERR_W] ? DIF_MAG_W'(-dif_c) : dif_c[DIF_MAG_W-1:0];
				term_q    <= '0;
			end
			ST_IMAG: begin
				dmag_q    <= prod_q[DMAG_W-1:0];
				int_neg_q <= integ_q[INT_W-1];
				int_mag_q <= integ_q[INT_W-1] ? -integ_q : integ_q;
			end
			ST_P: begin
				term_q <= term_c;
			end
			ST_IL: begin
				part_q <= {{(PART_W-24){1'b0}}, prod_q[47:24]};
			end
			ST_IH: begin
				part_q <= part_q + {{(PART_W-PROD_W){1'b0}}, prod_q};
			end
			ST_IA: begin
				term_q <= term_c;
				part_q <= {{(PART_W-(PROD_W-12)){1'b0}}, prod_q[PROD_W-1:12]};
			end
			ST_DH: begin
				part_q <= part_q + {{(PART_W-DMAG_W-12){1'b0}}, prod_q[DMAG_W-1:0], 12'd0};
			end
			ST_DA: begin
				term_q <= term_c;
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && out_free) begin
			out_q <= {{(OUT_DATA_W-OUT_USED_W){1'b0}}, meas_q, enabled_q, duty_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

endmodule

// ----- rtl/core/mspc_div.sv -----
// Radix-2 restoring divider producing one quotient bit per cycle.
module mspc_div import mspc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(SCALE_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SCALE_W-1:0]   dvd_q;
	logic [IN_DATA_W-1:0] dvs_q;
	logic [IN_DATA_W-1:0] rem_q;
	logic [IN_DATA_W:0]   shifted;
	logic [IN_DATA_W:0]   trial;
	logic                 fits;

	assign shifted = {rem_q, dvd_q[SCALE_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SCALE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial[IN_DATA_W-1:0] : shifted[IN_DATA_W-1:0];
			dvd_q <= {dvd_q[SCALE_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

// ----- rtl/core/mspc_checker.sv -----
// Port-level checker of the motor speed regulator and its bind to the top level.
`include "motor_speed_pid_controller_defines.svh"

module mspc_checker import mspc_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	`MSPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "Result changed while the receiver stalled.")
	`MSPC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "Input ready straight after a transfer.")
	`MSPC_ASSERT(a_duty_range, m_tvalid |-> (m_tdata[DUTY_W-1:0] <= DUTY_LIM), "Duty value above its limit.")
	`MSPC_ASSERT(a_pad_zero, m_tvalid |-> (m_tdata[OUT_DATA_W-1:OUT_USED_W] == '0), "Padding bits of the result are not zero.")

endmodule

bind motor_speed_pid_controller mspc_checker u_mspc_checker (.*);

// ----- sim/tb_top.sv -----
// Self-checking testbench of the motor speed regulator, with its own fixed-point loop predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mspc_pkg::*;

	localparam longint INTEGRAL_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint INTEGRAL_LO = -64'sh0000_8000_0000_0000;
	localparam longint DRIVE_LIMIT = longint'(DUTY_MAX) * 65536;
	localparam int     DRAIN_LIMIT = 20000;
	localparam int     SETTLE_CYCLES = 40;
	localparam int     PHASE_ITEMS = 230;

	typedef struct {
		logic [GAIN_W-1:0]  kp;
		logic [GAIN_W-1:0]  ki;
		logic [GAIN_W-1:0]  kd;
		logic [GAIN_W-1:0]  period;
		logic [RATE_W-1:0]  rate;
		logic [SCALE_W-1:0] scale;
	} tuning_t;

	typedef struct {
		logic [TARGET_W-1:0] target;
		logic [SPEED_W-1:0]  measured;
		longint              prev_err;
		longint              integral;
		longint              drive;
		logic [DUTY_W-1:0]   duty;
		logic                enabled;
	} regulator_t;

	typedef struct {
		logic [DUTY_W-1:0]  duty;
		logic               running;
		logic [SPEED_W-1:0] speed;
	} status_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // operand_value
	logic [IN_USER_W-1:0]  s_tuser = '0;   // action
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // duty, running, speed_rpm, zero padding
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	tuning_t    tuning;
	regulator_t regulator;
	status_t    expected_status_q[$];

	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	int stall_request = 0;
	int stall_left = 0;
	int rx_gap = 0;
	int failures = 0;
	int n_items = 0;
	int n_checked = 0;
	int n_ticks = 0;
	int n_settings = 0;

	motor_speed_pid_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic tuning_t default_tuning();
		tuning_t t;
		t.kp = KP_RESET;
		t.ki = KI_RESET;
		t.kd = KD_RESET;
		t.period = PERIOD_RESET;
		t.rate = RATE_RESET;
		t.scale = SCALE_RESET;
		return t;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end
		if (r < 95) begin
			return int'($urandom_range(1, 3));
		end
		return int'($urandom_range(8, 40));
	endfunction

	function automatic longint signed_gain_product(longint v, logic [GAIN_W-1:0] gain, int shift);
		logic [63:0] mag;
		logic [79:0] prod;
		longint      r;
		mag = (v < 0) ? 64'(-v) : 64'(v);
		mag = mag & 64'h0000_FFFF_FFFF_FFFF;
		prod = mag * gain;
		prod = prod >> shift;
		r = longint'(prod[63:0]);
		return (v < 0) ? -r : r;
	endfunction

	function automatic status_t regulator_step(action_t act, logic [IN_DATA_W-1:0] val);
		longint             err;
		longint             diff;
		longint             inc;
		longint             deriv;
		longint             term;
		logic [SCALE_W-1:0] quotient;
		status_t            s;
		case (act)
			ACT_SETPOINT: begin
				regulator.target = val[TARGET_W-1:0];
				if (regulator.target != 0) begin
					regulator.enabled = 1'b1;
				end else begin
					regulator.enabled = 1'b0;
					regulator.prev_err = 0;
					regulator.integral = 0;
					regulator.drive = 0;
					regulator.measured = '0;
				end
			end
			ACT_MEASURE: begin
				if (val != 0) begin
					quotient = tuning.scale / SCALE_W'(val);
					regulator.measured = (quotient > SCALE_W'(24'hFF_FFFF)) ? '1 :
						quotient[SPEED_W-1:0];
				end
			end
			ACT_TICK: begin
				if (regulator.enabled) begin
					n_ticks++;
					err = longint'(regulator.target) * 256 - longint'(regulator.measured);
					diff = err - regulator.prev_err;
					inc = ((err < 0 ? -err : err) * longint'(tuning.period)) >>> 8;
					deriv = diff * longint'(tuning.rate);
					regulator.integral += (err < 0) ? -inc : inc;
					if (regulator.integral > INTEGRAL_HI) begin
						regulator.integral = INTEGRAL_HI;
					end
					if (regulator.integral < INTEGRAL_LO) begin
						regulator.integral = INTEGRAL_LO;
					end
					term = signed_gain_product(err, tuning.kp, 12)
						+ signed_gain_product(regulator.integral, tuning.ki, 28)
						+ signed_gain_product(deriv, tuning.kd, 12);
					regulator.drive += term;
					if (regulator.drive > DRIVE_LIMIT) begin
						regulator.drive = DRIVE_LIMIT;
					end
					if (regulator.drive < 0) begin
						regulator.drive = 0;
					end
					regulator.duty = DUTY_W'(regulator.drive >>> 16);
					regulator.prev_err = err;
				end
			end
			default: begin
			end
		endcase
		s.duty = regulator.duty;
		s.running = regulator.enabled;
		s.speed = regulator.measured;
		return s;
	endfunction

	task automatic send_item(action_t act, logic [IN_DATA_W-1:0] val);
		int gap;
		gap = tx_idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= val;
		s_tuser <= act;
		do @(posedge clk); while (!s_tready);
		expected_status_q.push_back(regulator_step(act, val));
		n_items++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		int waited;
		s_tvalid <= 1'b0;
		waited = 0;
		while (expected_status_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (expected_status_q.size() != 0) begin
			$error("%0d expected results never arrived", expected_status_q.size());
			failures++;
			expected_status_q.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_tuning(tuning_t t);
		cfg_reg_t              r;
		logic [CFG_DATA_W-1:0] word;
		r = r.first();
		for (int i = 0; i < r.num(); i++) begin
			word = $urandom;
			case (r)
				CFG_KP:     word[GAIN_W-1:0] = t.kp;
				CFG_KI:     word[GAIN_W-1:0] = t.ki;
				CFG_KD:     word[GAIN_W-1:0] = t.kd;
				CFG_PERIOD: word[GAIN_W-1:0] = t.period;
				CFG_RATE:   word[RATE_W-1:0] = t.rate;
				CFG_SCALE:  word = t.scale;
				default: begin
				end
			endcase
			cfg_wr_en <= 1'b1;
			cfg_index <= r;
			cfg_data <= word;
			@(negedge clk);
			r = r.next();
		end
		cfg_wr_en <= 1'b0;
		tuning = t;
		n_settings++;
	endtask

	// Mostly well-formed control traffic: start the loop, feed speeds near the target, tick.
	task automatic pick_random_item(output action_t act, output logic [IN_DATA_W-1:0] val);
		int     r;
		longint desired;
		longint count;
		r = $urandom_range(0, 99);
		val = IN_DATA_W'($urandom);
		act = ACT_NOP;
		if (!regulator.enabled && r < 70) begin
			act = ACT_SETPOINT;
			if (val[TARGET_W-1:0] == 0) begin
				val[0] = 1'b1;
			end
		end else if (r < 6) begin
			act = ACT_SETPOINT;
			if ($urandom_range(0, 3) == 0) begin
				val[TARGET_W-1:0] = '0;
			end
		end else if (r < 40) begin
			act = ACT_MEASURE;
			if (r < 9) begin
				val = '0;
			end else if (r < 24 && tuning.scale != 0) begin
				desired = longint'(regulator.target) * 256
					+ longint'($urandom_range(0, 16383)) - 8192;
				if (desired < 1) begin
					desired = 1;
				end
				count = longint'(tuning.scale) / desired;
				if (count < 1) begin
					count = 1;
				end
				if (count > 65535) begin
					count = 65535;
				end
				val = IN_DATA_W'(count);
			end
		end else if (r < 96) begin
			act = ACT_TICK;
		end
	endtask

	task automatic test_defaults_directed();
		send_item(ACT_TICK, 16'hFFFF);
		send_item(ACT_NOP, 16'hFFFF);
		send_item(ACT_MEASURE, 16'h0000);
		send_item(ACT_MEASURE, 16'h0001);
		send_item(ACT_MEASURE, 16'hFFFF);
		send_item(ACT_SETPOINT, 16'hFF00);
		send_item(ACT_SETPOINT, 16'h01FF);
		send_item(ACT_MEASURE, 16'h0000);
		send_item(ACT_MEASURE, 16'd160);
		repeat (3) send_item(ACT_TICK, 16'h0000);
		send_item(ACT_SETPOINT, 16'd100);
		send_item(ACT_MEASURE, 16'hFFFF);
		repeat (3) send_item(ACT_TICK, 16'h5A5A);
		send_item(ACT_NOP, 16'h0000);
		send_item(ACT_SETPOINT, 16'h0000);
		send_item(ACT_TICK, 16'h0000);
		wait_drained();
	endtask

	task automatic test_tuning_extremes();
		tuning_t t;
		t = '{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF};
		apply_tuning(t);
		send_item(ACT_MEASURE, 16'h0001);
		send_item(ACT_SETPOINT, 16'h00FF);
		send_item(ACT_MEASURE, 16'hFFFF);
		repeat (2) send_item(ACT_TICK, 16'h0000);
		send_item(ACT_MEASURE, 16'h0001);
		repeat (2) send_item(ACT_TICK, 16'hFFFF);
		send_item(ACT_SETPOINT, 16'h0000);
		wait_drained();
		t = '{24'h0, 24'h0, 24'h0, 24'h0, 16'h0, 32'h0};
		apply_tuning(t);
		send_item(ACT_SETPOINT, 16'h0001);
		send_item(ACT_MEASURE, 16'h0007);
		repeat (2) send_item(ACT_TICK, 16'h0000);
		send_item(ACT_SETPOINT, 16'h0000);
		wait_drained();
	endtask

	task automatic test_random_regulation();
		tuning_t              t;
		action_t              act;
		logic [IN_DATA_W-1:0] val;
		int                   counted;
		for (int phase = 0; phase < 8; phase++) begin
			t = default_tuning();
			if (phase != 0) begin
				t.kp = GAIN_W'($urandom >> $urandom_range(8, 31));
				t.ki = GAIN_W'($urandom >> $urandom_range(8, 31));
				t.kd = GAIN_W'($urandom >> $urandom_range(8, 31));
				t.period = GAIN_W'($urandom >> $urandom_range(8, 31));
				t.rate = RATE_W'($urandom >> $urandom_range(16, 31));
				t.scale = ($urandom_range(0, 1) == 0) ? $urandom_range(1000000, 20000000) :
					$urandom;
			end
			tx_idle_en = (phase % 3 != 1);
			rx_idle_en = (phase % 3 != 1);
			apply_tuning(t);
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				pick_random_item(act, val);
				if (act != ACT_NOP && !(act == ACT_TICK && !regulator.enabled)) begin
					counted++;
				end
				send_item(act, val);
			end
			wait_drained();
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	task automatic test_output_backpressure();
		action_t              act;
		logic [IN_DATA_W-1:0] val;
		tx_idle_en = 1'b0;
		apply_tuning(default_tuning());
		stall_request = 400;
		repeat (30) begin
			pick_random_item(act, val);
			send_item(act, val);
		end
		wait_drained();
		tx_idle_en = 1'b1;
	endtask

	// The receiver counts its own long stall when one is requested.
	always @(negedge clk) begin
		if (stall_request > 0) begin
			stall_left = stall_request;
			stall_request = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!rx_idle_en) begin
			m_tready <= 1'b1;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			rx_gap = pick_gap();
		end
	end

	always @(posedge clk) begin : check_results
		status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_status_q.size() == 0) begin
				$error("result transfer with no expectation waiting, m_tdata=%h", m_tdata);
				failures++;
			end else begin
				want = expected_status_q.pop_front();
				n_checked++;
				if (m_tdata[DUTY_W-1:0] !== want.duty) begin
					$error("duty: expected %0d, actual %0d", want.duty, m_tdata[DUTY_W-1:0]);
					failures++;
				end
				if (m_tdata[DUTY_W] !== want.running) begin
					$error("running: expected %0d, actual %0d", want.running, m_tdata[DUTY_W]);
					failures++;
				end
				if (m_tdata[DUTY_W+1 +: SPEED_W] !== want.speed) begin
					$error("speed_rpm: expected %0d, actual %0d", want.speed,
						m_tdata[DUTY_W+1 +: SPEED_W]);
					failures++;
				end
				if (m_tdata[OUT_DATA_W-1:OUT_USED_W] !== '0) begin
					$error("padding: expected 0, actual %0h", m_tdata[OUT_DATA_W-1:OUT_USED_W]);
					failures++;
				end
			end
		end
	end

	initial begin
		#15_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		tuning = default_tuning();
		regulator = '{8'd0, 24'd0, 0, 0, 0, 10'd0, 1'b0};
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_defaults_directed();
		test_tuning_extremes();
		test_random_regulation();
		test_output_backpressure();
		$display("Sent %0d items under %0d register settings, %0d of them live control ticks.",
			n_items, n_settings, n_ticks);
		$display("Checked %0d results, with full-scale, zero and random tunings and a long stall.",
			n_checked);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
